// ----- hw/rtl/nplp_pkg.sv -----
// Package with the item types, codes and lookup functions of the note-name parser and loop player.
package nplp_pkg;

   localparam int unsigned NPLP_NOTE_DEPTH = 1024;

   localparam logic [6:0] DEFAULT_NOTE_RESET = 7'd72;
   localparam int signed  SEMIS_PER_OCTAVE = 12;
   localparam int signed  MIDI_MAX         = 127;
   localparam logic [9:0] OCTAVE_SAT       = 10'd1023;
   localparam logic [2:0] TOKEN_LEN_SAT    = 3'd5;

   localparam logic OP_TEXT  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_SHARP   = 8'h23;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_B    = 8'h42;
   localparam logic [7:0] CHAR_UP_G    = 8'h47;
   localparam logic [7:0] CHAR_LOW_A   = 8'h61;
   localparam logic [7:0] CHAR_LOW_B   = 8'h62;
   localparam logic [7:0] CHAR_LOW_Z   = 8'h7a;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic       op;
      logic [7:0] text_char;
      logic       clip_end;
   } req_item_type;

   typedef struct packed {
      logic [6:0] note;
      logic       from_default;
   } rsp_item_type;

   typedef enum logic [2:0] {
      PH_LETTER,
      PH_ACC,
      PH_SIGN,
      PH_DIGIT1,
      PH_DIGITS,
      PH_DONE
   } parse_phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_CLOSE,
      CTL_FETCH
   } ctl_state_type;

   // Semitone of letters A..G, plus one, so that a flat on C still fits unsigned.
   function automatic logic [3:0] letter_semi_plus1(input logic [2:0] idx);
      logic [3:0] semi;
      case (idx)
         3'd0:    semi = 4'd10;
         3'd1:    semi = 4'd12;
         3'd2:    semi = 4'd1;
         3'd3:    semi = 4'd3;
         3'd4:    semi = 4'd5;
         3'd5:    semi = 4'd6;
         3'd6:    semi = 4'd8;
         default: semi = 4'd0;
      endcase
      return semi;
   endfunction

endpackage

// ----- hw/rtl/note_name_parser_and_loop_player_unit.sv -----
// Top level of the note-name parser and loop player: token parser, note store and play head.
// A text item with clip_end on a non-space also closes its token in the next cycle, in the close
// state. A fetch result passes the registered read port of the note store, then the output register;
// on an empty store the default note goes straight into the output register.
// Throughput: one text item per cycle, but no item is taken in the close or fetch state.
// Reset (synchronous, active high) clears control and parser; the note store is left as is.
module note_name_parser_and_loop_player_unit
   import nplp_pkg::*;
#(
   parameter int unsigned NOTE_DEPTH = NPLP_NOTE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_write_enable,
   input  logic [6:0]   csr_write_data
);

   localparam int unsigned ADDR_W = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(NOTE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(NOTE_DEPTH);

   // Control and configuration registers.
   ctl_state_type   state_ff, state_in;
   logic [6:0]      default_note_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_item_ff, rsp_item_in;

   // Token parser registers.
   logic [2:0]      len_ff, len_in;
   parse_phase_type phase_ff, phase_in;
   logic [3:0]      semi_ff, semi_in;
   logic            neg_ff, neg_in;
   logic [9:0]      oct_ff, oct_in;
   logic            invalid_ff, invalid_in;

   // Note store: one write port for appended notes, one registered read port for the head.
   logic [6:0]      note_mem [NOTE_DEPTH];
   logic [6:0]      mem_rdata_ff;
   logic            mem_we;
   logic            mem_re;
   logic [6:0]      mem_wdata;

   logic            req_accept;
   logic            out_blocked;

   // Result of feeding the incoming character into the parser.
   logic [2:0]      feed_len;
   parse_phase_type feed_phase;
   logic [3:0]      feed_semi;
   logic            feed_neg;
   logic [9:0]      feed_oct;
   logic            feed_invalid;
   logic [7:0]      char_up;
   logic [13:0]     oct_step;
   logic            is_digit;
   logic            in_digit_phase;

   // Token close value.
   logic signed [11:0] oct_signed;
   logic signed [15:0] midi;
   logic               token_ok;
   logic [6:0]         close_note;

   logic               feed_now;
   logic               close_now;
   logic [CNT_W-1:0]   head_plus1;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   // Text items pass while a result waits; a fetch needs the output register to be free.
   assign req_stall   = (state_ff != CTL_IDLE) || ((req_item.op == OP_FETCH) && out_blocked);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;

   // Character parser. Letter, optional accidental, optional minus, then octave digits.
   always_comb begin
      feed_len       = (len_ff < TOKEN_LEN_SAT) ? len_ff + 3'd1 : len_ff;
      feed_phase     = phase_ff;
      feed_semi      = semi_ff;
      feed_neg       = neg_ff;
      feed_oct       = oct_ff;
      feed_invalid   = invalid_ff;
      char_up        = (req_item.text_char inside {[CHAR_LOW_A:CHAR_LOW_Z]}) ?
                       req_item.text_char - CASE_OFFSET : req_item.text_char;
      is_digit       = req_item.text_char inside {[CHAR_ZERO:CHAR_NINE]};
      oct_step       = {1'b0, oct_ff, 3'b0} + {3'b0, oct_ff, 1'b0}
                       + 14'(req_item.text_char - CHAR_ZERO);
      in_digit_phase = 1'b0;
      if (!invalid_ff) begin
         case (phase_ff)
            PH_LETTER: begin
               if (char_up inside {[CHAR_UP_A:CHAR_UP_G]}) begin
                  feed_semi  = letter_semi_plus1(3'(char_up - CHAR_UP_A));
                  feed_phase = PH_ACC;
               end else begin
                  feed_invalid = 1'b1;
               end
            end
            PH_ACC: begin
               if (req_item.text_char == CHAR_SHARP) begin
                  feed_semi  = semi_ff + 4'd1;
                  feed_phase = PH_SIGN;
               end else if (req_item.text_char == CHAR_LOW_B ||
                            req_item.text_char == CHAR_UP_B) begin
                  feed_semi  = semi_ff - 4'd1;
                  feed_phase = PH_SIGN;
               end else if (req_item.text_char == CHAR_MINUS) begin
                  feed_neg   = 1'b1;
                  feed_phase = PH_DIGIT1;
               end else begin
                  in_digit_phase = 1'b1;
               end
            end
            PH_SIGN: begin
               if (req_item.text_char == CHAR_MINUS) begin
                  feed_neg   = 1'b1;
                  feed_phase = PH_DIGIT1;
               end else begin
                  in_digit_phase = 1'b1;
               end
            end
            PH_DIGIT1, PH_DIGITS: begin
               in_digit_phase = 1'b1;
            end
            default: begin
               in_digit_phase = 1'b0;
            end
         endcase
         if (in_digit_phase) begin
            if (is_digit) begin
               feed_oct   = (oct_step > 14'(OCTAVE_SAT)) ? OCTAVE_SAT : oct_step[9:0];
               feed_phase = PH_DIGITS;
            end else if (phase_ff == PH_DIGITS) begin
               feed_phase = PH_DONE;
            end else begin
               feed_invalid = 1'b1;
            end
         end
      end
   end

   // Note number of the token held in the parser registers.
   always_comb begin
      oct_signed = neg_ff ? -$signed({2'b00, oct_ff}) : $signed({2'b00, oct_ff});
      midi       = (16'(oct_signed) + 16'sd2) * 16'(SEMIS_PER_OCTAVE)
                   + $signed({12'd0, semi_ff}) - 16'sd1;
      token_ok   = !invalid_ff && (len_ff >= 3'd2) && (len_ff <= 3'd4) &&
                   (phase_ff == PH_DIGITS || phase_ff == PH_DONE);
      close_note = (token_ok && midi >= 16'sd0 && midi <= 16'(MIDI_MAX)) ? midi[6:0] : 7'd0;
   end

   assign head_plus1 = CNT_W'(head_ff) + 1'b1;

   // Sequencer: text characters, token close and the note fetch from the store.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      rsp_valid_in = out_blocked;
      rsp_item_in  = rsp_item_ff;
      len_in       = len_ff;
      phase_in     = phase_ff;
      semi_in      = semi_ff;
      neg_in       = neg_ff;
      oct_in       = oct_ff;
      invalid_in   = invalid_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wdata    = close_note;
      feed_now     = 1'b0;
      close_now    = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            if (req_accept) begin
               if (req_item.op == OP_FETCH) begin
                  if (count_ff == '0) begin
                     rsp_valid_in             = 1'b1;
                     rsp_item_in.note         = default_note_ff;
                     rsp_item_in.from_default = 1'b1;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = CTL_FETCH;
                  end
               end else if (req_item.text_char == CHAR_SPACE) begin
                  // A space closes the token; clip_end on a space closes nothing more.
                  close_now = 1'b1;
               end else begin
                  feed_now = 1'b1;
                  if (req_item.clip_end) begin
                     state_in = CTL_CLOSE;
                  end
               end
            end
         end
         CTL_CLOSE: begin
            close_now = 1'b1;
            state_in  = CTL_IDLE;
         end
         CTL_FETCH: begin
            rsp_valid_in             = 1'b1;
            rsp_item_in.note         = mem_rdata_ff;
            rsp_item_in.from_default = 1'b0;
            head_in  = (head_plus1 >= count_ff) ? '0 : head_plus1[ADDR_W-1:0];
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
      if (feed_now) begin
         len_in     = feed_len;
         phase_in   = feed_phase;
         semi_in    = feed_semi;
         neg_in     = feed_neg;
         oct_in     = feed_oct;
         invalid_in = feed_invalid;
      end
      if (close_now && len_ff != 3'd0) begin
         // Once the store is full, further notes are dropped.
         if (count_ff < DEPTH_CNT) begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
         end
         len_in     = 3'd0;
         phase_in   = PH_LETTER;
         semi_in    = 4'd0;
         neg_in     = 1'b0;
         oct_in     = 10'd0;
         invalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= CTL_IDLE;
         default_note_ff <= DEFAULT_NOTE_RESET;
         count_ff        <= '0;
         head_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         len_ff          <= 3'd0;
         phase_ff        <= PH_LETTER;
         semi_ff         <= 4'd0;
         neg_ff          <= 1'b0;
         oct_ff          <= 10'd0;
         invalid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         phase_ff     <= phase_in;
         semi_ff      <= semi_in;
         neg_ff       <= neg_in;
         oct_ff       <= oct_in;
         invalid_ff   <= invalid_in;
         if (csr_write_enable) begin
            default_note_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // Writes go to the entry at the count, reads to the head, which is always below the count.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[count_ff[ADDR_W-1:0]] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= note_mem[head_ff];
      end
   end

   // The fill count never passes the store depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("note count exceeds store depth");

   // The play head always points at a written entry when the store holds notes.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && head_ff == '0) || (CNT_W'(head_ff) < count_ff))
      else $error("play head outside the stored notes");

   // The output register is free whenever stored read data is about to be loaded.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_FETCH) |-> !rsp_valid_ff || !rsp_stall)
      else $error("fetch would overwrite a pending result");

   // A fetch on an empty store gives the default note on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_item.op == OP_FETCH && count_ff == '0)
      |=> (rsp_valid_ff && rsp_item_ff.from_default))
      else $error("empty-store fetch did not return the default note");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the note-name parser and loop player: directed and random items.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nplp_pkg::*;

   // The clear of the last token can trail its item, so writes to the default
   // note wait SETTLE_CYCLES once the result queue is empty.
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 8;
   localparam int RANDOM_ITEMS   = 100;
   localparam int FILL_EXTRA     = 6;
   localparam int TAIL_ROUNDS    = 15;
   localparam int DRAIN_AT       = 60;
   localparam int HOLDOFF_AT     = 20;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int IDLE_LIMIT     = 2000;

   typedef enum logic [1:0] {
      ENTRY_ITEM,
      ENTRY_CSR,
      ENTRY_DRAIN
   } entry_kind_type;

   // One entry of the sender's queue: an item to offer, a default-note write, or a
   // pause until every note already asked for has come back.
   typedef struct {
      entry_kind_type kind;
      req_item_type   item;
      logic [6:0]     data;
   } feed_entry_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_write_enable = 1'b0;
   logic [6:0]   csr_write_data = 7'd0;

   note_name_parser_and_loop_player_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predicted state of the block: the note store, its count and play
   // head, the token being parsed, and the default note.
   // ------------------------------------------------------------------
   logic [6:0]      note_tbl [NPLP_NOTE_DEPTH];
   int unsigned     notes_held;
   int unsigned     play_ptr;
   logic [2:0]      tok_len;
   parse_phase_type tok_phase;
   logic [4:0]      tok_semi;
   logic            tok_neg;
   logic [9:0]      tok_oct;
   logic            tok_bad;
   logic [6:0]      model_default;
   int              letter_semi [7] = '{9, 11, 0, 2, 4, 5, 7};

   rsp_item_type   notes_due [$];
   feed_entry_type pending [$];

   int fails = 0;
   int n_items = 0;
   int notes_seen = 0;

   // Token closes caused by the queued text, counted as it is queued, so that the
   // fill phase knows how many one-character tokens it takes to overflow the store.
   int   closes_made = 0;
   logic gen_open = 1'b0;

   function automatic void clear_token();
      tok_len   = 3'd0;
      tok_phase = PH_LETTER;
      tok_semi  = 5'd0;
      tok_neg   = 1'b0;
      tok_oct   = 10'd0;
      tok_bad   = 1'b0;
   endfunction

   // The note store is left alone: only entries below the count are ever read.
   function automatic void reset_model();
      notes_held    = 0;
      play_ptr      = 0;
      model_default = DEFAULT_NOTE_RESET;
      clear_token();
   endfunction

   // One non-space character of a token. The semitone is kept plus one so that a
   // flat on C stays non-negative; the length counts every character, even after
   // the token has turned bad or its digits have ended.
   function automatic void take_char(input logic [7:0] c);
      logic [7:0] up;
      int         v;
      logic       is_digit;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (tok_len < TOKEN_LEN_SAT) tok_len = tok_len + 3'd1;
      if (tok_bad) return;
      if (tok_phase == PH_LETTER) begin
         up = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_OFFSET : c;
         if (up >= CHAR_UP_A && up <= CHAR_UP_G) begin
            tok_semi  = 5'(letter_semi[up - CHAR_UP_A] + 1);
            tok_phase = PH_ACC;
         end else begin
            tok_bad = 1'b1;
         end
         return;
      end
      if (tok_phase == PH_ACC && (c == CHAR_SHARP || c == CHAR_LOW_B || c == CHAR_UP_B)) begin
         tok_semi  = (c == CHAR_SHARP) ? tok_semi + 5'd1 : tok_semi - 5'd1;
         tok_phase = PH_SIGN;
         return;
      end
      if ((tok_phase == PH_ACC || tok_phase == PH_SIGN) && c == CHAR_MINUS) begin
         tok_neg   = 1'b1;
         tok_phase = PH_DIGIT1;
         return;
      end
      // Whatever follows the octave digits is ignored.
      if (tok_phase == PH_DONE) return;
      if (is_digit) begin
         v         = int'(tok_oct) * 10 + int'(c) - int'(CHAR_ZERO);
         tok_oct   = (v > int'(OCTAVE_SAT)) ? OCTAVE_SAT : 10'(v);
         tok_phase = PH_DIGITS;
      end else if (tok_phase == PH_DIGITS) begin
         tok_phase = PH_DONE;
      end else begin
         tok_bad = 1'b1;
      end
   endfunction

   // An empty token stores nothing; a bad, too short, too long or out of range one
   // stores zero; a full store drops the note.
   function automatic void close_token();
      int         oct;
      int         midi;
      logic [6:0] val;
      if (tok_len == 3'd0) return;
      val = 7'd0;
      if (!tok_bad && tok_len >= 3'd2 && tok_len <= 3'd4 &&
          (tok_phase == PH_DIGITS || tok_phase == PH_DONE)) begin
         oct  = tok_neg ? -int'(tok_oct) : int'(tok_oct);
         midi = (oct + 2) * SEMIS_PER_OCTAVE + int'(tok_semi) - 1;
         if (midi >= 0 && midi <= MIDI_MAX) val = 7'(midi);
      end
      if (notes_held < NPLP_NOTE_DEPTH) begin
         note_tbl[notes_held] = val;
         notes_held++;
      end
      clear_token();
   endfunction

   // Folds one accepted item into the predicted state; a fetch queues the note
   // that the block must return for it.
   function automatic void absorb_item(input req_item_type it);
      rsp_item_type r;
      if (it.op == OP_TEXT) begin
         if (it.text_char == CHAR_SPACE) close_token();
         else take_char(it.text_char);
         if (it.clip_end) close_token();
      end else if (notes_held == 0) begin
         r.note         = model_default;
         r.from_default = 1'b1;
         notes_due      = {notes_due, r};
      end else begin
         if (play_ptr >= notes_held) play_ptr = 0;
         r.note         = note_tbl[play_ptr];
         r.from_default = 1'b0;
         notes_due      = {notes_due, r};
         play_ptr++;
         if (play_ptr >= notes_held) play_ptr = 0;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers that fill the sender's queue.
   // ------------------------------------------------------------------
   function automatic void push_char(input logic [7:0] c, input logic fin);
      feed_entry_type e;
      e.kind           = ENTRY_ITEM;
      e.item.op        = OP_TEXT;
      e.item.text_char = c;
      e.item.clip_end  = fin;
      e.data           = 7'd0;
      pending          = {pending, e};
      n_items++;
      if (c == CHAR_SPACE) begin
         if (gen_open) closes_made++;
         gen_open = 1'b0;
      end else begin
         gen_open = 1'b1;
      end
      if (fin && gen_open) begin
         closes_made++;
         gen_open = 1'b0;
      end
   endfunction

   // The text byte of a fetch is unused, so it carries random bits.
   function automatic void push_fetch(input logic fin);
      feed_entry_type e;
      e.kind           = ENTRY_ITEM;
      e.item.op        = OP_FETCH;
      e.item.text_char = 8'($urandom_range(0, 255));
      e.item.clip_end  = fin;
      e.data           = 7'd0;
      pending          = {pending, e};
      n_items++;
   endfunction

   function automatic void push_ctl(input entry_kind_type kind, input logic [6:0] value);
      feed_entry_type e;
      e.kind  = kind;
      e.item  = '0;
      e.data  = value;
      pending = {pending, e};
   endfunction

   function automatic void push_text(input string s, input logic close_last);
      int i;
      for (i = 0; i < s.len(); i++) begin
         push_char(s[i], close_last && (i == s.len() - 1));
      end
   endfunction

   // A note name with random content: mostly well formed, sometimes with a wrong
   // first character, no digits or trailing junk, closed in one of the ways the
   // block allows. Fetches are mixed in between the characters.
   function automatic void gen_token();
      logic [7:0] chars [$];
      int         idx;
      int         n_dig;
      int         r;
      int         i;
      idx = $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) chars = {chars, 8'($urandom_range(0, 255))};
      else if ($urandom_range(0, 1) == 1) chars = {chars, CHAR_LOW_A + 8'(idx)};
      else chars = {chars, CHAR_UP_A + 8'(idx)};
      r = $urandom_range(0, 5);
      if (r == 0) chars = {chars, CHAR_SHARP};
      else if (r == 1) chars = {chars, CHAR_LOW_B};
      else if (r == 2) chars = {chars, CHAR_UP_B};
      if ($urandom_range(0, 3) == 0) chars = {chars, CHAR_MINUS};
      r = $urandom_range(0, 99);
      n_dig = (r < 70) ? 1 : (r < 90) ? 2 : (r < 97) ? 3 : 0;
      for (i = 0; i < n_dig; i++) chars = {chars, CHAR_ZERO + 8'($urandom_range(0, 9))};
      if ($urandom_range(0, 6) == 0) chars = {chars, 8'($urandom_range(0, 255))};
      r = $urandom_range(0, 99);
      for (i = 0; i < chars.size(); i++) begin
         if ($urandom_range(0, 6) == 0) push_fetch(1'($urandom_range(0, 1)));
         push_char(chars[i], (r < 15) && (i == chars.size() - 1));
      end
      if (r >= 15 && r < 25) begin
         push_char(CHAR_SPACE, 1'b1);
      end else if (r >= 25) begin
         push_char(CHAR_SPACE, 1'b0);
         if (r >= 85) push_char(CHAR_SPACE, 1'b0);
      end
   endfunction

   // Random bytes of random length, ended by a space.
   function automatic void gen_noise();
      int i;
      int n;
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      push_char(CHAR_SPACE, 1'b0);
   endfunction

   // Idle lengths: mostly short, a few long.
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // Driver. Items come off the pending queue; the predictor sees each one at
   // the edge where it is accepted. Default-note writes and pauses wait until
   // every expected note has come and the parser has had time to settle.
   // ------------------------------------------------------------------
   int gap_left = 0;
   int burst_left = 0;
   int settle = 0;

   always @(posedge clock) begin
      logic         valid_nx;
      logic         we_nx;
      logic [6:0]   data_nx;
      req_item_type item_nx;
      valid_nx = req_valid;
      item_nx  = req_item;
      we_nx    = 1'b0;
      data_nx  = csr_write_data;
      if (reset) begin
         reset_model();
         valid_nx = 1'b0;
         gap_left = 0;
         settle   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_item(req_item);
            valid_nx = 1'b0;
         end
         // A stalled item stays on the port unchanged until it is taken.
         if (!valid_nx) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() != 0) begin
               if (pending[0].kind == ENTRY_ITEM) begin
                  valid_nx = 1'b1;
                  item_nx  = pending[0].item;
                  void'(pending.pop_front());
                  settle   = 0;
                  // Stretches with no gaps at all alternate with random gaps.
                  if (burst_left > 0) begin
                     burst_left--;
                     gap_left = 0;
                  end else if ($urandom_range(0, 29) == 0) begin
                     burst_left = $urandom_range(20, 80);
                     gap_left   = 0;
                  end else begin
                     gap_left = pick_idle();
                  end
               end else if (notes_due.size() != 0) begin
                  settle = 0;
               end else if (settle < SETTLE_CYCLES) begin
                  settle++;
               end else begin
                  if (pending[0].kind == ENTRY_CSR) begin
                     we_nx         = 1'b1;
                     data_nx       = pending[0].data;
                     model_default = pending[0].data;
                  end
                  void'(pending.pop_front());
                  settle = 0;
               end
            end
         end
      end
      req_valid        <= valid_nx;
      req_item         <= item_nx;
      csr_write_enable <= we_nx;
      csr_write_data   <= data_nx;
   end

   // ------------------------------------------------------------------
   // Monitor. Each accepted result is checked against the oldest expected
   // note. The result side stalls at random, and once, after a couple dozen
   // results, it holds off for a long stretch so that the block backs up and
   // stalls its input while the sender keeps offering items.
   // ------------------------------------------------------------------
   int  stall_left = 0;
   logic holdoff_done = 1'b0;

   always @(posedge clock) begin
      rsp_item_type want;
      logic         stall_nx;
      stall_nx = rsp_stall;
      if (reset) begin
         stall_nx   = 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            notes_seen++;
            if (notes_due.size() == 0) begin
               $display("%0t: note %0d from_default %0b arrived with nothing expected",
                        $time, rsp_item.note, rsp_item.from_default);
               fails++;
            end else begin
               want = notes_due.pop_front();
               if (rsp_item.note !== want.note) begin
                  $display("%0t: note expected %0d actual %0d",
                           $time, want.note, rsp_item.note);
                  fails++;
               end
               if (rsp_item.from_default !== want.from_default) begin
                  $display("%0t: from_default expected %0b actual %0b",
                           $time, want.from_default, rsp_item.from_default);
                  fails++;
               end
            end
         end
         if (!holdoff_done && notes_seen >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            stall_nx     = 1'b1;
            stall_left   = HOLDOFF_CYCLES;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (!rsp_stall && $urandom_range(0, 2) == 0) begin
            stall_nx   = 1'b1;
            stall_left = pick_idle();
         end else begin
            stall_nx   = 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 6);
         end
      end
      rsp_stall <= stall_nx;
   end

   // Watchdog: ends the run when nothing has moved for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("note_name_parser_and_loop_player_unit regression: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------
   initial begin
      int  r;
      int  i;
      logic drained;
      logic [7:0] c;
      drained = 1'b0;

      // The default note can only be seen while the store is empty, so the
      // register is swept through its extremes before any token closes. A
      // clip_end on a fetch must be ignored.
      push_fetch(1'b1);
      push_ctl(ENTRY_CSR, 7'd0);
      push_fetch(1'b0);
      push_ctl(ENTRY_CSR, 7'd127);
      push_fetch(1'b1);
      push_ctl(ENTRY_CSR, 7'($urandom_range(0, 127)));
      push_fetch(1'b0);

      // Lowest note, a flat on C that drops below range, the highest note,
      // repeated spaces, junk after the digits, a token closed by clip_end on a
      // space, and the byte extremes as token characters.
      push_text("C-2 ", 1'b0);
      push_text("Cb-2", 1'b1);
      push_text("G8 ", 1'b0);
      push_char(CHAR_SPACE, 1'b0);
      push_text("a0zz", 1'b0);
      push_char(CHAR_SPACE, 1'b1);
      push_char(8'h00, 1'b0);
      push_char(8'hff, 1'b1);
      push_text("B#7", 1'b1);
      push_fetch(1'b0);
      push_fetch(1'b1);
      push_fetch(1'b0);
      push_ctl(ENTRY_CSR, 7'($urandom_range(0, 127)));

      // Random part: mostly note names, some noise and extra fetches. Once, the
      // sender pauses until all expected notes are back.
      while (n_items < RANDOM_ITEMS) begin
         if (!drained && n_items >= DRAIN_AT) begin
            push_ctl(ENTRY_DRAIN, 7'd0);
            drained = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 75) gen_token();
         else if (r < 85) gen_noise();
         else push_fetch(1'($urandom_range(0, 1)));
      end
      push_ctl(ENTRY_CSR, 7'($urandom_range(0, 127)));

      // Fill the store with one-character tokens until it overflows.
      while (closes_made < int'(NPLP_NOTE_DEPTH) + FILL_EXTRA) begin
         c = 8'($urandom_range(0, 255));
         if (c == CHAR_SPACE) c = CHAR_UP_A;
         push_char(c, 1'b1);
         if ($urandom_range(0, 39) == 0) push_fetch(1'b0);
      end

      // With the store full, new notes are dropped while playback goes on.
      for (i = 0; i < TAIL_ROUNDS; i++) begin
         if ($urandom_range(0, 2) == 0) gen_token();
         else push_fetch(1'($urandom_range(0, 1)));
      end
      push_ctl(ENTRY_CSR, 7'($urandom_range(0, 127)));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid || notes_due.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      if (notes_due.size() != 0) begin
         $display("%0t: %0d expected notes never arrived", $time, notes_due.size());
         fails++;
      end
      if (fails == 0) begin
         $display("note_name_parser_and_loop_player_unit regression: pass");
      end else begin
         $display("note_name_parser_and_loop_player_unit regression: fail");
      end
      $finish;
   end

endmodule
